// ===== design/mlpq_pkg.sv =====
// Shared types, sizes and codes of the multilevel priority queue.
package mlpq_pkg;

    // Sizes of the queue
    localparam int MAX_LEVELS  = 8;
    localparam int STORE_DEPTH = 64;
    localparam int ITEM_WIDTH  = 32;

    // Fixed port field widths
    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 3;
    localparam int HANDLE_W = 32;
    localparam int CFG_W   = 4;

    // Derived widths
    localparam int LVL_IDX_W = $clog2(MAX_LEVELS);
    localparam int NLV_W     = $clog2(MAX_LEVELS + 1);
    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int STORE_W   = (ITEM_WIDTH < HANDLE_W) ? ITEM_WIDTH : HANDLE_W;

    // Reset value of the active level count
    localparam int LEVELS_RESET = 8;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROMOTE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LEVEL_W-1:0]  level;
        logic [HANDLE_W-1:0] item;
    } in_item_t;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] item_out;
        logic                all_empty;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic issue;
        logic complete;
        logic report;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/multilevel_priority_queue.sv =====
// Top level of the multilevel priority queue: sequencer plus datapath.
//
//  Channel   Signals                    Direction  Transfer
//  in        in_valid/in_stall/in_data   into block valid high, stall low
//  out       out_valid/out_stall/out_data out of block valid high, stall low
//  cfg       cfg_we/cfg_data             into block cfg_we high
//
// Each item passes through accept, issue (store reads, promote shift),
// complete (pointer update from the link read), report into the result register.
// The shared single-port-pair item and link stores set this sequence.
// Reset is asynchronous; link entries reset by per-entry written bits, so no
// clearing pass is needed. A stalled result holds the next item in report.
module multilevel_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mlpq_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mlpq_pkg::out_item_t           out_data,
    input  logic                          cfg_we,
    input  logic [mlpq_pkg::CFG_W-1:0]    cfg_data
);

    mlpq_pkg::ctrl_cmd_t  cmd;
    mlpq_pkg::dp_status_t status;

    mlpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mlpq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/mlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mlpq_ctrl.sv =====
// Operation sequencer of the multilevel priority queue.
module mlpq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mlpq_pkg::dp_status_t  status,
    output mlpq_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_ISSUE    = 4'b0010,
        ST_COMPLETE = 4'b0100,
        ST_REPORT   = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Advance through issue, complete and report for each item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:    state_next = ST_COMPLETE;
            ST_COMPLETE: state_next = ST_REPORT;
            ST_REPORT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Drive commands and the input stall
    assign in_stall     = (state_reg != ST_IDLE);
    assign cmd.accept   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.issue    = (state_reg == ST_ISSUE);
    assign cmd.complete = (state_reg == ST_COMPLETE);
    assign cmd.report   = (state_reg == ST_REPORT) && status.out_free;

endmodule

// ===== design/mlpq_datapath.sv =====
// Level pointers, shared item and link stores, result register of the queue.
module mlpq_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mlpq_pkg::ctrl_cmd_t                  cmd,
    output mlpq_pkg::dp_status_t                 status,
    input  mlpq_pkg::in_item_t                   in_data,
    input  logic                                 cfg_we,
    input  logic [mlpq_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output mlpq_pkg::out_item_t                  out_data
);

    localparam int LW = mlpq_pkg::LVL_IDX_W;
    localparam int AW = mlpq_pkg::ADDR_W;
    localparam int CW = mlpq_pkg::CNT_W;
    localparam int NL = mlpq_pkg::MAX_LEVELS;
    localparam int SW = mlpq_pkg::STORE_W;

    // Configuration and level bookkeeping
    logic [mlpq_pkg::CFG_W-1:0] levels_reg;
    logic [mlpq_pkg::NLV_W-1:0] active_n;

    logic [AW-1:0] head_reg [NL];
    logic [AW-1:0] head_next [NL];
    logic [AW-1:0] tail_reg [NL];
    logic [AW-1:0] tail_next [NL];
    logic [CW-1:0] count_reg [NL];
    logic [CW-1:0] count_next [NL];

    logic [AW-1:0] free_head_reg;
    logic [AW-1:0] free_head_next;
    logic [CW-1:0] free_count_reg;
    logic [CW-1:0] free_count_next;

    // One bit per link entry: clear means the entry still links to its successor
    logic [mlpq_pkg::STORE_DEPTH-1:0] link_written_reg;
    logic [mlpq_pkg::STORE_DEPTH-1:0] link_written_next;

    // Per-item working registers
    mlpq_pkg::in_item_t op_reg;
    logic               enq_ok_reg;
    logic               deq_hit_reg;
    logic [LW-1:0]      deq_lvl_reg;
    logic [AW-1:0]      node_reg;
    logic               lk_valid_reg;
    logic               res_ok_reg;
    logic [mlpq_pkg::HANDLE_W-1:0] res_item_reg;

    logic                out_valid_reg;
    mlpq_pkg::out_item_t out_data_reg;

    // Store ports
    logic          item_wr_en;
    logic [AW-1:0] item_wr_addr;
    logic [SW-1:0] item_wr_data;
    logic [SW-1:0] item_rd_data;
    logic          link_wr_en;
    logic [AW-1:0] link_wr_addr;
    logic [AW-1:0] link_wr_data;
    logic [AW-1:0] link_rd_data;
    logic          rd_en;
    logic [AW-1:0] node_sel;

    // Decoded operation
    logic [LW-1:0] enq_lvl;
    logic          enq_ok;
    logic          deq_hit;
    logic [LW-1:0] deq_lvl;
    logic [AW-1:0] lk_val;
    logic [AW-1:0] node_succ;
    logic          any_busy;

    // Cap the level count at the number of levels built
    assign active_n = (32'(levels_reg) > mlpq_pkg::MAX_LEVELS)
                      ? mlpq_pkg::NLV_W'(mlpq_pkg::MAX_LEVELS)
                      : mlpq_pkg::NLV_W'(levels_reg);

    // Enqueue target and its admission check
    assign enq_lvl = LW'(op_reg.level);
    assign enq_ok  = (32'(op_reg.level) < 32'(active_n)) && (free_count_reg != '0);

    // Find the lowest-numbered active level holding an item
    always_comb
    begin
        deq_hit = 1'b0;
        deq_lvl = '0;
        for (int i = 0; i < NL; i++)
        begin
            if (!deq_hit && (i < 32'(active_n)) && (count_reg[i] != '0))
            begin
                deq_hit = 1'b1;
                deq_lvl = LW'(i);
            end
        end
    end

    // Check every active level for items
    always_comb
    begin
        any_busy = 1'b0;
        for (int i = 0; i < NL; i++)
        begin
            if ((i < 32'(active_n)) && (count_reg[i] != '0))
            begin
                any_busy = 1'b1;
            end
        end
    end

    // Node read at issue: free head for enqueue, level head for dequeue
    assign node_sel = (op_reg.kind == mlpq_pkg::KIND_ENQUEUE) ? free_head_reg
                                                              : head_reg[deq_lvl];
    assign rd_en    = cmd.issue;

    // Untouched link entries follow the initial chain
    assign node_succ = (32'(node_reg) == mlpq_pkg::STORE_DEPTH - 1) ? '0 : node_reg + 1'b1;
    assign lk_val    = lk_valid_reg ? link_rd_data : node_succ;

    // Next state of pointers, counts and store writes
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        free_head_next    = free_head_reg;
        free_count_next   = free_count_reg;
        item_wr_en        = 1'b0;
        item_wr_addr      = free_head_reg;
        item_wr_data      = SW'(op_reg.item);
        link_wr_en        = 1'b0;
        link_wr_addr      = tail_reg[enq_lvl];
        link_wr_data      = free_head_reg;

        if (cmd.issue)
        begin
            case (op_reg.kind)
                mlpq_pkg::KIND_ENQUEUE:
                begin
                    // Store the handle and chain it behind the current tail
                    item_wr_en = enq_ok;
                    link_wr_en = enq_ok && (count_reg[enq_lvl] != '0);
                end
                mlpq_pkg::KIND_PROMOTE:
                begin
                    // Append level 1 to level 0
                    if ((active_n >= mlpq_pkg::NLV_W'(2)) && (count_reg[1] != '0))
                    begin
                        if (count_reg[0] == '0)
                        begin
                            head_next[0] = head_reg[1];
                        end
                        else
                        begin
                            link_wr_en   = 1'b1;
                            link_wr_addr = tail_reg[0];
                            link_wr_data = head_reg[1];
                        end
                        tail_next[0]  = tail_reg[1];
                        count_next[0] = count_reg[0] + count_reg[1];
                    end
                    // Move higher levels down one number
                    for (int k = 1; k < NL - 1; k++)
                    begin
                        if ((k + 1) < 32'(active_n))
                        begin
                            head_next[k]  = head_reg[k + 1];
                            tail_next[k]  = tail_reg[k + 1];
                            count_next[k] = count_reg[k + 1];
                        end
                    end
                    // Empty the last active level
                    if (active_n >= mlpq_pkg::NLV_W'(2))
                    begin
                        count_next[LW'(active_n - 1'b1)] = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.complete)
        begin
            if ((op_reg.kind == mlpq_pkg::KIND_ENQUEUE) && enq_ok_reg)
            begin
                // Take the node off the free list and make it the new tail
                if (count_reg[enq_lvl] == '0)
                begin
                    head_next[enq_lvl] = node_reg;
                end
                tail_next[enq_lvl]  = node_reg;
                count_next[enq_lvl] = count_reg[enq_lvl] + 1'b1;
                free_head_next      = lk_val;
                free_count_next     = free_count_reg - 1'b1;
            end
            if ((op_reg.kind == mlpq_pkg::KIND_DEQUEUE) && deq_hit_reg)
            begin
                // Advance the level head and push the node on the free list
                head_next[deq_lvl_reg]  = lk_val;
                count_next[deq_lvl_reg] = count_reg[deq_lvl_reg] - 1'b1;
                link_wr_en              = 1'b1;
                link_wr_addr            = node_reg;
                link_wr_data            = free_head_reg;
                free_head_next          = node_reg;
                free_count_next         = free_count_reg + 1'b1;
            end
        end
    end

    // Mark link entries once written
    always_comb
    begin
        link_written_next = link_written_reg;
        if (link_wr_en)
        begin
            link_written_next[link_wr_addr] = 1'b1;
        end
    end

    // Control state and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg       <= mlpq_pkg::CFG_W'(mlpq_pkg::LEVELS_RESET);
            free_head_reg    <= '0;
            free_count_reg   <= CW'(mlpq_pkg::STORE_DEPTH);
            link_written_reg <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_data;
            end
            free_head_reg    <= free_head_next;
            free_count_reg   <= free_count_next;
            link_written_reg <= link_written_next;
            count_reg        <= count_next;
            if (cmd.report)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (cmd.accept)
        begin
            op_reg <= in_data;
        end
        if (cmd.issue)
        begin
            enq_ok_reg   <= enq_ok;
            deq_hit_reg  <= deq_hit;
            deq_lvl_reg  <= deq_lvl;
            node_reg     <= node_sel;
            lk_valid_reg <= link_written_reg[node_sel];
        end
        if (cmd.complete)
        begin
            case (op_reg.kind)
                mlpq_pkg::KIND_ENQUEUE: res_ok_reg <= enq_ok_reg;
                mlpq_pkg::KIND_DEQUEUE: res_ok_reg <= deq_hit_reg;
                default:                res_ok_reg <= 1'b1;
            endcase
            res_item_reg <= ((op_reg.kind == mlpq_pkg::KIND_DEQUEUE) && deq_hit_reg)
                            ? mlpq_pkg::HANDLE_W'(item_rd_data) : '0;
        end
        if (cmd.report)
        begin
            out_data_reg.ok        <= res_ok_reg;
            out_data_reg.item_out  <= res_item_reg;
            out_data_reg.all_empty <= !any_busy;
        end
    end

    mlpq_ram #(
        .WIDTH (SW),
        .DEPTH (mlpq_pkg::STORE_DEPTH)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (item_wr_en),
        .wr_addr (item_wr_addr),
        .wr_data (item_wr_data),
        .rd_en   (rd_en),
        .rd_addr (node_sel),
        .rd_data (item_rd_data)
    );

    mlpq_ram #(
        .WIDTH (AW),
        .DEPTH (mlpq_pkg::STORE_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (node_sel),
        .rd_data (link_rd_data)
    );

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// ===== design/mlpq_checker.sv =====
// Port-level checks of the multilevel priority queue, bound to the top level.
module mlpq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input mlpq_pkg::out_item_t        out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a second item straight after the first");

    // A handle is only returned with success
    a_item_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.item_out != '0) |-> out_data.ok)
        else $error("handle returned without success");

    // A result appears only while an item is in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

endmodule

bind multilevel_priority_queue mlpq_checker u_mlpq_checker (.*);
